/* sv/stfmt_pkg.sv */
// shared types, constants and microcode table of the subtitle time range formatter
// no dependencies; imported by every module of the block
`default_nettype none

package stfmt_pkg;

	localparam int HOUR_DIGITS = 4;
	localparam int IN_W = 36;
	localparam int CHAR_W = 8;
	localparam longint unsigned MS_PER_HOUR = 64'd3600000;

	function automatic longint unsigned pow10(input int n);
		longint unsigned p;
		int i;
		p = 64'd1;
		for (i = 0; i < n; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

	// largest printable time, all nines for the hours then 59:59,999
	localparam longint unsigned LIM = pow10(HOUR_DIGITS) * MS_PER_HOUR - 64'd1;
	localparam int TIME_W = $clog2(LIM + 64'd1);
	localparam int SAT_W = (TIME_W > IN_W) ? TIME_W : IN_W;

	// digit positions: hours, min tens, min ones, sec tens, sec ones, ms x3
	localparam int NDIGITS = HOUR_DIGITS + 7;
	localparam int IDX_W = $clog2(NDIGITS);
	localparam int NPLACE = 2 ** IDX_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NDIGITS - 1);
	localparam logic [IDX_W-1:0] IDX_HOURS = IDX_W'(HOUR_DIGITS);
	localparam logic [IDX_W-1:0] IDX_PAD = IDX_W'(HOUR_DIGITS - 2);
	localparam logic [IDX_W-1:0] IDX_HOUR_END = IDX_W'(HOUR_DIGITS - 1);
	localparam logic [IDX_W-1:0] IDX_MIN_END = IDX_W'(HOUR_DIGITS + 1);
	localparam logic [IDX_W-1:0] IDX_SEC_END = IDX_W'(HOUR_DIGITS + 3);

	typedef logic [TIME_W-1:0] time_t;
	typedef time_t place_tab_t [NPLACE];

	localparam longint unsigned LOW_PLACE [7] = '{
		64'd600000, 64'd60000, 64'd10000, 64'd1000, 64'd100, 64'd10, 64'd1
	};

	function automatic place_tab_t make_place();
		place_tab_t t;
		int i;
		for (i = 0; i < NPLACE; i++) begin
			t[i] = '0;
			if (i < HOUR_DIGITS) begin
				t[i] = TIME_W'(pow10(HOUR_DIGITS - 1 - i) * MS_PER_HOUR);
			end else if (i < NDIGITS) begin
				t[i] = TIME_W'(LOW_PLACE[i - HOUR_DIGITS]);
			end
		end
		return t;
	endfunction

	// weight of one unit of each digit position, in milliseconds
	localparam place_tab_t PLACE = make_place();

	localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_LOAD,
		OP_TRY,
		OP_DIGIT,
		OP_SEP,
		OP_NOP,
		OP_LIT
	} op_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_ALWAYS,
		JMP_MORE,
		JMP_END
	} jmp_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_LOAD_S = 4'd0;
	localparam pc_t PC_TRY3   = 4'd1;
	localparam pc_t PC_TRY2   = 4'd2;
	localparam pc_t PC_TRY1   = 4'd3;
	localparam pc_t PC_TRY0   = 4'd4;
	localparam pc_t PC_DIGIT  = 4'd5;
	localparam pc_t PC_SEP    = 4'd6;
	localparam pc_t PC_BRANCH = 4'd7;
	localparam pc_t PC_LIT0   = 4'd8;
	localparam pc_t PC_LIT1   = 4'd9;
	localparam pc_t PC_LIT2   = 4'd10;
	localparam pc_t PC_LIT3   = 4'd11;
	localparam pc_t PC_LIT4   = 4'd12;
	localparam pc_t PC_LOAD_E = 4'd13;
	localparam pc_t PC_IDLE   = 4'd14;

	typedef struct packed {
		op_t               op;
		logic              sel;
		logic [1:0]        sh;
		logic [CHAR_W-1:0] lit;
		jmp_t              jmp;
		pc_t               target;
	} ctrl_t;

	typedef struct packed {
		logic more;
		logic on_end;
	} stat_t;

	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		w = '{op: OP_IDLE, sel: 1'b0, sh: 2'd0, lit: CH_NONE, jmp: JMP_NONE, target: PC_IDLE};
		unique case (pc)
			PC_LOAD_S: w.op = OP_LOAD;
			PC_TRY3: begin
				w.op = OP_TRY;
				w.sh = 2'd3;
			end
			PC_TRY2: begin
				w.op = OP_TRY;
				w.sh = 2'd2;
			end
			PC_TRY1: begin
				w.op = OP_TRY;
				w.sh = 2'd1;
			end
			PC_TRY0: begin
				w.op = OP_TRY;
				w.sh = 2'd0;
			end
			PC_DIGIT: w.op = OP_DIGIT;
			PC_SEP: begin
				w.op = OP_SEP;
				w.jmp = JMP_MORE;
				w.target = PC_TRY3;
			end
			PC_BRANCH: begin
				w.op = OP_NOP;
				w.jmp = JMP_END;
				w.target = PC_IDLE;
			end
			PC_LIT0: begin
				w.op = OP_LIT;
				w.lit = CH_SPACE;
			end
			PC_LIT1: begin
				w.op = OP_LIT;
				w.lit = CH_DASH;
			end
			PC_LIT2: begin
				w.op = OP_LIT;
				w.lit = CH_DASH;
			end
			PC_LIT3: begin
				w.op = OP_LIT;
				w.lit = CH_GT;
			end
			PC_LIT4: begin
				w.op = OP_LIT;
				w.lit = CH_SPACE;
			end
			PC_LOAD_E: begin
				w.op = OP_LOAD;
				w.sel = 1'b1;
				w.jmp = JMP_ALWAYS;
				w.target = PC_TRY3;
			end
			default: w.op = OP_IDLE;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* sv/stfmt_seq.sv */
// microcode sequencer: step counter, control store lookup and conditional jumps
// depends on stfmt_pkg
`default_nettype none

module stfmt_seq
	import stfmt_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   accept,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy
);

	pc_t  pc_q;
	logic take;

	always_comb begin
		ctrl = ucode(pc_q);
		busy = (pc_q != PC_IDLE);
		unique case (ctrl.jmp)
			JMP_NONE:   take = 1'b0;
			JMP_ALWAYS: take = 1'b1;
			JMP_MORE:   take = stat.more;
			JMP_END:    take = stat.on_end;
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (accept) begin
			pc_q <= PC_LOAD_S;
		end else if (ctrl.op != OP_IDLE) begin
			pc_q <= take ? ctrl.target : pc_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* sv/stfmt_dp.sv */
// datapath: input capture, clamp and saturation, restoring digit extraction, character output
// depends on stfmt_pkg
`default_nettype none

module stfmt_dp
	import stfmt_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire  [IN_W-1:0]   start_ms,
	input  wire  [IN_W-1:0]   end_ms,
	input  ctrl_t             ctrl,
	output stat_t             stat,
	output logic              char_strobe,
	output logic [CHAR_W-1:0] out_char,
	output logic              last_char
);

	logic [IN_W-1:0]   start_q;
	logic [IN_W-1:0]   end_q;
	time_t             rem_q;
	logic [3:0]        dig_q;
	logic [IDX_W-1:0]  idx_q;
	logic              seen_q;
	logic              sel_q;
	logic              strobe_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	time_t             weight;
	logic              fits;
	logic [SAT_W-1:0]  src;
	time_t             sat_val;
	logic              blank;
	logic              more;
	logic              sep_has;
	logic [CHAR_W-1:0] sep_chr;
	logic              emit;
	logic [CHAR_W-1:0] emit_chr;
	logic              emit_last;

	always_comb begin
		weight = PLACE[idx_q] << ctrl.sh;
		fits = (rem_q >= weight);
		src = SAT_W'(ctrl.sel ? end_q : start_q);
		sat_val = (src > SAT_W'(LIM)) ? TIME_W'(LIM) : TIME_W'(src);
		blank = (idx_q < IDX_PAD) && (dig_q == 4'd0) && !seen_q;
		more = (idx_q != IDX_LAST);
		sep_has = 1'b1;
		priority if (idx_q == IDX_HOUR_END) begin
			sep_chr = CH_COLON;
		end else if (idx_q == IDX_MIN_END) begin
			sep_chr = CH_COLON;
		end else if (idx_q == IDX_SEC_END) begin
			sep_chr = CH_COMMA;
		end else begin
			sep_chr = CH_NONE;
			sep_has = 1'b0;
		end
		emit = 1'b0;
		emit_chr = CH_NONE;
		emit_last = 1'b0;
		unique case (ctrl.op)
			OP_DIGIT: begin
				emit = !blank;
				emit_chr = CH_ZERO + {4'd0, dig_q};
				emit_last = sel_q && !more;
			end
			OP_SEP: begin
				emit = more && sep_has;
				emit_chr = sep_chr;
			end
			OP_LIT: begin
				emit = 1'b1;
				emit_chr = ctrl.lit;
			end
			default: emit = 1'b0;
		endcase
		stat.more = more;
		stat.on_end = sel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			seen_q   <= 1'b0;
			sel_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			unique case (ctrl.op)
				OP_LOAD: begin
					sel_q  <= ctrl.sel;
					idx_q  <= '0;
					seen_q <= 1'b0;
				end
				OP_DIGIT: begin
					if (idx_q < IDX_HOURS && dig_q != 4'd0) begin
						seen_q <= 1'b1;
					end
				end
				OP_SEP: begin
					if (more) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_ms;
			end_q   <= (end_ms < start_ms) ? start_ms : end_ms;
		end
		char_q <= emit_chr;
		last_q <= emit_last;
		unique case (ctrl.op)
			OP_LOAD: begin
				rem_q <= sat_val;
				dig_q <= 4'd0;
			end
			OP_TRY: begin
				if (fits) begin
					rem_q <= rem_q - weight;
					dig_q <= dig_q | (4'd1 << ctrl.sh);
				end
			end
			OP_DIGIT: dig_q <= 4'd0;
			default: dig_q <= dig_q;
		endcase
	end

	assign char_strobe = strobe_q;
	assign out_char = char_q;
	assign last_char = strobe_q & last_q;

endmodule

`default_nettype wire

/* sv/subtitle_time_range_formatter.sv */
// top level of the subtitle time range formatter: sequencer plus datapath
// depends on stfmt_pkg, stfmt_seq and stfmt_dp
//
// channel   signals                       transaction taken when
// input     start, busy, start_ms, end_ms  start high and busy low at a rising edge
// result    char_strobe, out_char,         char_strobe high; held one cycle only
//           last_char
//
// one item keeps the block busy while each time value runs one load step plus six
// steps per digit position (four restoring subtract trials, a digit emit, a
// separator step) and one branch step, and the arrow text takes five more steps;
// the shared subtract and compare unit in the datapath serves every trial step
// reset clears the step counter to idle and drops the strobe; no clearing pass
// the receiver cannot stall, so characters leave as soon as they are formed
`default_nettype none

module subtitle_time_range_formatter
	import stfmt_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire  [IN_W-1:0]   start_ms,
	input  wire  [IN_W-1:0]   end_ms,
	output logic              char_strobe,
	output logic [CHAR_W-1:0] out_char,
	output logic              last_char
);

	// control word from the microcode store and status flags back to it
	ctrl_t ctrl;
	stat_t stat;
	logic  accept;

	// an input transaction only lands when the sequencer sits on its idle step
	assign accept = start & ~busy;

	stfmt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// end is clamped to start on capture; saturation happens as each time is loaded
	stfmt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.start_ms    (start_ms),
		.end_ms      (end_ms),
		.ctrl        (ctrl),
		.stat        (stat),
		.char_strobe (char_strobe),
		.out_char    (out_char),
		.last_char   (last_char)
	);

endmodule

`default_nettype wire

/* sv/stfmt_chk.sv */
// port-level checker for the subtitle time range formatter, bound to the top level
// depends on stfmt_pkg
`default_nettype none

module stfmt_chk
	import stfmt_pkg::*;
(
	input wire              clk,
	input wire              arst_n,
	input wire              start,
	input wire              busy,
	input wire [IN_W-1:0]   start_ms,
	input wire [IN_W-1:0]   end_ms,
	input wire              char_strobe,
	input wire [CHAR_W-1:0] out_char,
	input wire              last_char
);

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting a transaction");

	// characters only appear while an item is in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !char_strobe)
		else $error("character strobe while idle");

	// the block returns to idle shortly after the final character
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> ##2 !busy)
		else $error("still busy after final character");

	// the final character is a millisecond digit
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> char_strobe && out_char >= CH_ZERO && out_char <= 8'h39)
		else $error("final character is not a digit");

	// only digits and the fixed punctuation are ever sent
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe |-> (out_char >= CH_ZERO && out_char <= 8'h39) || out_char == CH_COLON
			|| out_char == CH_COMMA || out_char == CH_SPACE || out_char == CH_DASH
			|| out_char == CH_GT)
		else $error("unexpected character");

endmodule

bind subtitle_time_range_formatter stfmt_chk u_chk (.*);

`default_nettype wire
